FILE: design/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants for the allocation table chain manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fca_pkg;

    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int ACTION_W       = 2;
    localparam int BLOCK_W        = 12;
    localparam int START_W        = 1;
    localparam int STATUS_W       = 2;
    localparam int COUNT_W        = 13;
    localparam int KIND_W         = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FORMAT = 2'd0,
        ACT_ALLOC  = 2'd1,
        ACT_FOLLOW = 2'd2,
        ACT_FREE   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_END     = 2'd2,
        STAT_CORRUPT = 2'd3
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        KIND_FREE = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINK = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_LINK,
        S_FRD,
        S_FCHK,
        S_WRD,
        S_WCHK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: design/fca_ram.sv
// ----------------------------------------------------------------------------
// fca_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/fat_chain_allocator.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Allocation table of linked block chains: format, allocate, follow, free.
// ----------------------------------------------------------------------------
// Request channel (i_in_valid / o_in_stall) takes action, block and start_new;
// result channel (o_out_valid / i_out_stall) returns status, block_out and
// freed_count, one result per request, in request order.
// One request is handled at a time; o_in_stall is high while it is worked on.
// The table sits in one RAM with one read and one write port; every step
// goes through that port, one entry at a time:
//   format   : every entry is cleared, one entry written per cycle
//   allocate : scan upward from the start block for a free entry, which is
//              marked as an end and linked onto the given block
//   follow   : one table read of the given block
//   free     : each chain entry is read, then cleared; the walk ends on an
//              end entry, or on block 0 or a free entry
// After reset the table is cleared by a pass over every entry during
// which no request is taken. A result waits in the output register while
// i_out_stall is high; the next request is taken meanwhile, but its result
// is held back until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_allocator #(
    parameter int NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [fca_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [fca_pkg::BLOCK_W-1:0]   i_block,
    input  wire logic [fca_pkg::START_W-1:0]   i_start_new,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [fca_pkg::STATUS_W-1:0]  o_status,
    output logic      [fca_pkg::BLOCK_W-1:0]   o_block_out,
    output logic      [fca_pkg::COUNT_W-1:0]   o_freed_count
);

    import fca_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int EW = KIND_W + AW;
    localparam int WW = ((AW > BLOCK_W) ? AW : BLOCK_W) + 1;

    t_state r_state, n_state;

    logic [AW:0]          r_ptr, n_ptr;
    logic [AW-1:0]        r_cptr, n_cptr;
    logic                 r_rvld, n_rvld;
    logic [AW-1:0]        r_cur, n_cur;
    logic [AW-1:0]        r_found, n_found;
    logic [AW:0]          r_cnt, n_cnt;
    logic                 r_link, n_link;
    logic                 r_fmt, n_fmt;
    t_status              r_rstat, n_rstat;
    logic [BLOCK_W-1:0]   r_rblk, n_rblk;
    logic                 r_ovalid, n_ovalid;
    logic [STATUS_W-1:0]  r_ostat, n_ostat;
    logic [BLOCK_W-1:0]   r_oblk, n_oblk;
    logic [COUNT_W-1:0]   r_ocnt, n_ocnt;

    logic          acc;
    logic          in_range;
    logic          blk_zero;
    logic          fresh;
    t_action       act;
    logic          issue_ok;
    logic          last_chk;
    logic          clr_last;
    logic          out_free;
    t_kind         rd_kind;
    logic [AW-1:0] rd_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    fca_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign acc        = i_in_valid && !o_in_stall;
    assign act        = t_action'(i_action);
    assign fresh      = i_start_new[0];
    assign blk_zero   = (i_block == '0);
    assign in_range   = (WW'(i_block) < WW'(NUM_BLOCKS));
    assign issue_ok   = (r_ptr < (AW + 1)'(NUM_BLOCKS));
    assign last_chk   = (r_cptr == AW'(NUM_BLOCKS - 1));
    assign clr_last   = (r_ptr[AW-1:0] == AW'(NUM_BLOCKS - 1));
    assign out_free   = !r_ovalid || !i_out_stall;
    assign rd_kind    = t_kind'(ram_rdata[EW-1 -: KIND_W]);
    assign rd_next    = ram_rdata[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = r_fmt ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    case (act)
                        ACT_FORMAT: n_state = S_CLEAR;
                        ACT_ALLOC: begin
                            n_state = (!fresh && !blk_zero && !in_range) ? S_DONE : S_SCAN;
                        end
                        ACT_FOLLOW: n_state = in_range ? S_FRD : S_DONE;
                        ACT_FREE:   n_state = in_range ? S_WRD : S_DONE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rvld && rd_kind == KIND_FREE) begin
                    n_state = S_MARK;
                end else if (r_rvld && last_chk) begin
                    n_state = S_DONE;
                end
            end
            S_MARK:  n_state = r_link ? S_LINK : S_DONE;
            S_LINK:  n_state = S_DONE;
            S_FRD:   n_state = S_FCHK;
            S_FCHK:  n_state = S_DONE;
            S_WRD:   n_state = (r_cur == '0) ? S_DONE : S_WCHK;
            S_WCHK:  n_state = (rd_kind == KIND_LINK) ? S_WRD : S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // table port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_cur;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[AW-1:0];
                ram_wdata = (r_ptr == '0) ? {KIND_END, AW'(0)} : {KIND_FREE, AW'(0)};
            end
            S_SCAN: begin
                ram_re    = issue_ok;
                ram_raddr = r_ptr[AW-1:0];
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = r_found;
                ram_wdata = {KIND_END, AW'(0)};
            end
            S_LINK: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur;
                ram_wdata = {KIND_LINK, r_found};
            end
            S_FRD: begin
                ram_re = 1'b1;
            end
            S_WRD: begin
                ram_re = (r_cur != '0);
            end
            S_WCHK: begin
                ram_we    = (rd_kind == KIND_END) || (rd_kind == KIND_LINK);
                ram_wdata = {KIND_FREE, AW'(0)};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_ptr    = r_ptr;
        n_cptr   = r_cptr;
        n_rvld   = r_rvld;
        n_cur    = r_cur;
        n_found  = r_found;
        n_cnt    = r_cnt;
        n_link   = r_link;
        n_fmt    = r_fmt;
        n_rstat  = r_rstat;
        n_rblk   = r_rblk;
        n_ovalid = r_ovalid && i_out_stall;
        n_ostat  = r_ostat;
        n_oblk   = r_oblk;
        n_ocnt   = r_ocnt;
        case (r_state)
            S_CLEAR: begin
                n_ptr = r_ptr + (AW + 1)'(1);
            end
            S_IDLE: begin
                if (acc) begin
                    n_cur   = AW'(i_block);
                    n_cnt   = '0;
                    n_rblk  = '0;
                    n_rstat = STAT_OK;
                    n_rvld  = 1'b0;
                    n_fmt   = (act == ACT_FORMAT);
                    n_link  = !fresh && !blk_zero;
                    n_ptr   = '0;
                    case (act)
                        ACT_ALLOC: begin
                            n_ptr = (fresh || blk_zero) ? (AW + 1)'(1) : (AW + 1)'(i_block);
                            if (!fresh && !blk_zero && !in_range) begin
                                n_rstat = STAT_NOSPACE;
                            end
                        end
                        ACT_FOLLOW, ACT_FREE: begin
                            if (!in_range) begin
                                n_rstat = STAT_CORRUPT;
                            end
                        end
                        default: begin
                            n_rstat = STAT_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rvld && rd_kind == KIND_FREE) begin
                    n_found = r_cptr;
                    n_rblk  = BLOCK_W'(r_cptr);
                end else if (r_rvld && last_chk) begin
                    n_rstat = STAT_NOSPACE;
                end else if (issue_ok) begin
                    n_cptr = r_ptr[AW-1:0];
                    n_rvld = 1'b1;
                    n_ptr  = r_ptr + (AW + 1)'(1);
                end
            end
            S_FCHK: begin
                case (rd_kind)
                    KIND_END:  n_rstat = STAT_END;
                    KIND_LINK: n_rblk  = BLOCK_W'(rd_next);
                    default:   n_rstat = STAT_CORRUPT;
                endcase
            end
            S_WRD: begin
                if (r_cur == '0) begin
                    n_rstat = STAT_CORRUPT;
                end
            end
            S_WCHK: begin
                case (rd_kind)
                    KIND_END: begin
                        n_cnt = r_cnt + (AW + 1)'(1);
                    end
                    KIND_LINK: begin
                        n_cnt = r_cnt + (AW + 1)'(1);
                        n_cur = rd_next;
                    end
                    default: n_rstat = STAT_CORRUPT;
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_rstat;
                    n_oblk   = r_rblk;
                    n_ocnt   = COUNT_W'(r_cnt);
                end
            end
            default: begin
                n_fmt = r_fmt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ptr    <= '0;
            r_rvld   <= 1'b0;
            r_fmt    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_rvld   <= n_rvld;
            r_fmt    <= n_fmt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cptr  <= n_cptr;
        r_cur   <= n_cur;
        r_found <= n_found;
        r_cnt   <= n_cnt;
        r_link  <= n_link;
        r_rstat <= n_rstat;
        r_rblk  <= n_rblk;
        r_ostat <= n_ostat;
        r_oblk  <= n_oblk;
        r_ocnt  <= n_ocnt;
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostat;
    assign o_block_out   = r_oblk;
    assign o_freed_count = r_ocnt;

`ifndef SYNTHESIS
    a_blk0_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_waddr == '0) |-> (r_state == S_CLEAR))
        else $error("block 0 written outside the clearing pass");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= (AW + 1)'(NUM_BLOCKS)))
        else $error("scan pointer ran past the table");

    a_reset_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !r_fmt) |-> !r_ovalid)
        else $error("result presented during clearing pass after reset");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished result not moved to output register");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fat_chain_allocator. A generator builds format,
// allocate, follow and free requests. It starts with boundary cases, then
// moves on to random chain building, walking and release, mixed with noise.
// Each request is scored against a shadow copy of the allocation table.
// Results are compared field by field, in order. Both sides idle at random,
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import fca_pkg::*;

    localparam int NBLK         = NUM_BLOCKS_DEF;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_REQS  = 117;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT_CYCLES = 6_000_000;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        t_action              action;
        logic [BLOCK_W-1:0]   block;
        logic [START_W-1:0]   start_new;
    } t_fat_req;

    typedef struct packed {
        t_status              status;
        logic [BLOCK_W-1:0]   block_out;
        logic [COUNT_W-1:0]   freed_count;
    } t_fat_resp;

    typedef struct packed {
        t_fat_req  req;
        t_fat_resp resp;
    } t_fat_job;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic [ACTION_W-1:0] i_action    = '0;
    logic [BLOCK_W-1:0]  i_block     = '0;
    logic [START_W-1:0]  i_start_new = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [BLOCK_W-1:0]  o_block_out;
    logic [COUNT_W-1:0]  o_freed_count;

    // shadow allocation table
    t_kind              fat_kind [NBLK];
    logic [BLOCK_W-1:0] fat_next [NBLK];

    t_fat_job  req_queue [$];
    t_fat_resp resp_due  [$];
    t_fat_resp want_resp;
    int        chain_heads [$];
    int        err_count = 0;
    int        resp_seen = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    logic      hold_on   = 1'b0;

    fat_chain_allocator #(
        .NUM_BLOCKS (NBLK)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_block       (i_block),
        .i_start_new   (i_start_new),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_block_out   (o_block_out),
        .o_freed_count (o_freed_count)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic void wipe_table();
        for (int b = 0; b < NBLK; b++) begin
            fat_kind[b] = KIND_FREE;
            fat_next[b] = '0;
        end
        fat_kind[0] = KIND_END;
    endfunction

    function automatic t_fat_resp apply_request(t_fat_req rq);
        t_fat_resp rs;
        int        pos;
        int        cur;
        int        nxt;
        rs = '0;
        rs.status = STAT_OK;
        case (rq.action)
            ACT_FORMAT: wipe_table();
            ACT_ALLOC: begin
                pos = (rq.start_new || rq.block == 0) ? 1 : int'(rq.block);
                while (pos < NBLK && fat_kind[pos] != KIND_FREE)
                    pos++;
                if (pos >= NBLK) begin
                    rs.status = STAT_NOSPACE;
                end else begin
                    fat_kind[pos] = KIND_END;
                    fat_next[pos] = '0;
                    if (!rq.start_new && rq.block != 0) begin
                        fat_kind[rq.block] = KIND_LINK;
                        fat_next[rq.block] = pos[BLOCK_W-1:0];
                    end
                    rs.block_out = pos[BLOCK_W-1:0];
                end
            end
            ACT_FOLLOW: begin
                case (fat_kind[rq.block])
                    KIND_END:  rs.status = STAT_END;
                    KIND_LINK: rs.block_out = fat_next[rq.block];
                    default:   rs.status = STAT_CORRUPT;
                endcase
            end
            default: begin
                // free walk: stops on block 0 or a free entry, corrupt unless an end is cleared
                rs.status = STAT_CORRUPT;
                cur = rq.block;
                for (int steps = 0; steps < NBLK; steps++) begin
                    if (cur == 0 || fat_kind[cur] == KIND_FREE)
                        break;
                    nxt = fat_next[cur];
                    rs.freed_count++;
                    if (fat_kind[cur] == KIND_END) begin
                        fat_kind[cur] = KIND_FREE;
                        fat_next[cur] = '0;
                        rs.status = STAT_OK;
                        break;
                    end
                    fat_kind[cur] = KIND_FREE;
                    fat_next[cur] = '0;
                    cur = nxt;
                end
            end
        endcase
        return rs;
    endfunction

    task automatic issue(input t_action act, input int blk, input bit fresh,
                         output t_fat_resp rs);
        t_fat_job job;
        job.req.action    = act;
        job.req.block     = blk[BLOCK_W-1:0];
        job.req.start_new = fresh;
        rs = apply_request(job.req);
        job.resp = rs;
        req_queue.push_back(job);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t tb_top mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                resp_due.push_back(req_queue[0].resp);
                void'(req_queue.pop_front());
                send_idle = pick_gap();
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_idle > 0) begin
                    send_idle--;
                    i_in_valid <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    i_in_valid  <= 1'b1;
                    i_action    <= req_queue[0].req.action;
                    i_block     <= req_queue[0].req.block;
                    i_start_new <= req_queue[0].req.start_new;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                resp_seen++;
                if (resp_due.size() == 0) begin
                    report_mismatch("result with no request outstanding, block_out",
                                    o_block_out, -1);
                end else begin
                    want_resp = resp_due.pop_front();
                    if (o_status !== want_resp.status)
                        report_mismatch("status", o_status, want_resp.status);
                    if (o_block_out !== want_resp.block_out)
                        report_mismatch("block_out", o_block_out, want_resp.block_out);
                    if (o_freed_count !== want_resp.freed_count)
                        report_mismatch("freed_count", o_freed_count, want_resp.freed_count);
                end
            end
            if (recv_idle > 0)
                recv_idle--;
            else
                recv_idle = pick_gap();
            i_out_stall <= hold_on || (recv_idle > 0);
        end
    end

    // long receiver hold-off so the block backs up onto its input
    initial begin
        wait (resp_seen >= 40);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        t_fat_resp rs;
        int        n;
        int        b;
        int        tail;
        int        pick;
        int        idx;
        int        len;

        wipe_table();

        // boundary cases
        issue(ACT_FORMAT, 0, 1'b0, rs);
        issue(ACT_FOLLOW, 0, 1'b0, rs);
        issue(ACT_FREE,   0, 1'b0, rs);
        issue(ACT_FOLLOW, 5, 1'b1, rs);
        issue(ACT_FREE,   5, 1'b1, rs);
        issue(ACT_ALLOC,  NBLK - 1, 1'b1, rs);
        issue(ACT_ALLOC,  1, 1'b0, rs);
        issue(ACT_ALLOC,  2, 1'b0, rs);
        issue(ACT_ALLOC,  0, 1'b0, rs);
        issue(ACT_FOLLOW, 1, 1'b0, rs);
        issue(ACT_FOLLOW, 3, 1'b0, rs);
        issue(ACT_ALLOC,  1, 1'b0, rs);        // relink over an existing link
        issue(ACT_ALLOC,  NBLK - 1, 1'b0, rs); // top block links to itself
        issue(ACT_ALLOC,  NBLK - 1, 1'b0, rs); // nothing free above
        issue(ACT_FOLLOW, NBLK - 1, 1'b0, rs);
        issue(ACT_FREE,   NBLK - 1, 1'b0, rs);
        issue(ACT_FREE,   1, 1'b0, rs);
        issue(ACT_FREE,   2, 1'b0, rs);        // orphaned tail of the relinked chain
        issue(ACT_ALLOC,  'hAAA, 1'b0, rs);
        issue(ACT_ALLOC,  'h555, 1'b0, rs);
        issue(ACT_FREE,   'hAAA, 1'b1, rs);
        issue(ACT_FORMAT, NBLK - 1, 1'b1, rs);
        issue(ACT_ALLOC,  0, 1'b1, rs);

        n = 0;
        while (n < RANDOM_REQS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                issue(ACT_ALLOC, $urandom_range(0, NBLK - 1), 1'b1, rs);
                n++;
                if (rs.status == STAT_OK) begin
                    tail = rs.block_out;
                    chain_heads.push_back(tail);
                    len = $urandom_range(0, 5);
                    for (int k = 0; k < len; k++) begin
                        issue(ACT_ALLOC, tail, 1'b0, rs);
                        n++;
                        if (rs.status == STAT_OK)
                            tail = rs.block_out;
                    end
                end
            end else if (pick < 55 && chain_heads.size() > 0) begin
                b = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    issue(ACT_FOLLOW, b, $urandom_range(0, 1), rs);
                    n++;
                    if (rs.status != STAT_OK)
                        break;
                    b = rs.block_out;
                end
            end else if (pick < 70 && chain_heads.size() > 0) begin
                idx = $urandom_range(0, chain_heads.size() - 1);
                issue(ACT_FREE, chain_heads[idx], $urandom_range(0, 1), rs);
                n++;
                chain_heads.delete(idx);
            end else if (pick < 73) begin
                issue(ACT_FORMAT, $urandom_range(0, NBLK - 1), $urandom_range(0, 1), rs);
                n++;
                chain_heads.delete();
            end else begin
                b = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, NBLK - 1);
                issue(t_action'($urandom_range(1, 3)), b, $urandom_range(0, 1), rs);
                n++;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_queue.size() != 0 || resp_due.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: filelist.f
design/fca_pkg.sv
design/fca_ram.sv
design/fat_chain_allocator.sv
tb/tb_top.sv
